[rtl/itf_pkg.sv]
// ----------------------------------------------------------------------------
// itf_pkg
// shared types, constants and helpers of the integer text formatter
// ----------------------------------------------------------------------------
package itf_pkg;

	localparam int VAL_W  = 64;
	localparam int DIG_W  = 4;
	localparam int NDIG   = 22;
	localparam int DBUF_W = NDIG * DIG_W;
	localparam int MAG_W  = VAL_W + 2;
	localparam int NDIG_W = $clog2(NDIG + 1);
	localparam int FW_W   = 6;
	localparam int CNT_W  = 6;

	localparam logic [1:0] RADIX_OCT = 2'd0;
	localparam logic [1:0] RADIX_DEC = 2'd1;
	localparam logic [1:0] RADIX_HEX = 2'd2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef enum logic [2:0] {
		CONV_IDLE,
		CONV_NEG,
		CONV_SHIFT,
		CONV_ALIGN,
		CONV_DONE
	} conv_state_t;

	typedef enum logic {
		EMIT_IDLE,
		EMIT_RUN
	} emit_state_t;

	// converted value handed from the converter to the emitter
	typedef struct packed {
		logic [DBUF_W-1:0] digits;
		logic [NDIG_W-1:0] ndig;
		logic              neg;
		logic              upper;
		logic              hexp;
		logic              octp;
		logic              zpad;
		logic              left;
		logic [FW_W-1:0]   width;
	} conv_res_t;

	function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
		logic [7:0] d8;
		d8 = {4'b0, d};
		if (d < 4'd10) begin
			return CH_ZERO + d8;
		end else begin
			return (upper ? CH_UA : CH_LA) + d8 - 8'd10;
		end
	endfunction

endpackage

[rtl/itf_in_if.sv]
// ----------------------------------------------------------------------------
// itf_in_if
// input channel: one value with its formatting flags
// ----------------------------------------------------------------------------
interface itf_in_if import itf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;
	logic             is_signed;
	logic [1:0]       radix;
	logic             upper_hex;
	logic [FW_W-1:0]  field_width;
	logic             left_justify;
	logic             zero_pad;
	logic             hex_prefix;
	logic             octal_prefix;

	modport source (
		output valid, value, is_signed, radix, upper_hex, field_width,
		output left_justify, zero_pad, hex_prefix, octal_prefix,
		input  ready
	);
	modport sink (
		input  valid, value, is_signed, radix, upper_hex, field_width,
		input  left_justify, zero_pad, hex_prefix, octal_prefix,
		output ready
	);
endinterface

[rtl/itf_out_if.sv]
// ----------------------------------------------------------------------------
// itf_out_if
// output channel: one ascii character per transaction
// ----------------------------------------------------------------------------
interface itf_out_if import itf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last_char;

	modport source (output valid, character, last_char, input ready);
	modport sink   (input valid, character, last_char, output ready);
endinterface

[rtl/itf_conv.sv]
// ----------------------------------------------------------------------------
// itf_conv
// digit-serial converter: nibble-serial negate of a negative signed value,
// then digit extraction (shift for octal and hex, double dabble for decimal), then strip of
// leading zero digits
// ----------------------------------------------------------------------------
module itf_conv import itf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	itf_in_if.sink     in_ch,
	output logic       res_valid,
	input  logic       res_ready,
	output conv_res_t  res
);

	conv_state_t       state_q, state_nx;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  mag_q;
	logic              carry_q;
	logic [1:0]        radix_q;
	logic [DBUF_W-1:0] dig_q;
	logic [NDIG_W-1:0] ndig_q;
	conv_res_t         flags_q;

	logic              accept;
	logic              cnt_end;
	logic              align_end;
	logic [DBUF_W-1:0] dabble;
	logic [DIG_W:0]    nsum;
	logic              in_neg;

	function automatic logic [CNT_W-1:0] conv_len(input logic [1:0] r);
		case (r)
			RADIX_OCT: return CNT_W'(NDIG - 1);
			RADIX_DEC: return CNT_W'(VAL_W - 1);
			default:   return CNT_W'(VAL_W / DIG_W - 1);
		endcase
	endfunction

	assign in_neg    = in_ch.is_signed & in_ch.value[VAL_W-1];
	assign cnt_end   = (cnt_q == '0);
	assign align_end = (ndig_q == NDIG_W'(1)) || (dig_q[DBUF_W-1 -: DIG_W] != '0);
	assign nsum      = {1'b0, ~mag_q[DIG_W-1:0]} + {{DIG_W{1'b0}}, carry_q};

	// add-3 correction on every bcd digit that is 5 or more
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (dig_q[i*DIG_W +: DIG_W] >= 4'd5) begin
				dabble[i*DIG_W +: DIG_W] = dig_q[i*DIG_W +: DIG_W] + 4'd3;
			end else begin
				dabble[i*DIG_W +: DIG_W] = dig_q[i*DIG_W +: DIG_W];
			end
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			CONV_IDLE:  if (in_ch.valid) state_nx = in_neg ? CONV_NEG : CONV_SHIFT;
			CONV_NEG:   if (cnt_end) state_nx = CONV_SHIFT;
			CONV_SHIFT: if (cnt_end) state_nx = CONV_ALIGN;
			CONV_ALIGN: if (align_end) state_nx = CONV_DONE;
			CONV_DONE:  if (res_ready) state_nx = CONV_IDLE;
			default:    state_nx = CONV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready = (state_q == CONV_IDLE);
		res_valid   = (state_q == CONV_DONE);
		accept      = in_ch.valid && in_ch.ready;
		res         = flags_q;
		res.digits  = dig_q;
		res.ndig    = ndig_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CONV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				cnt_q <= in_neg ? CNT_W'(VAL_W / DIG_W - 1) : conv_len(in_ch.radix);
			end else if (state_q == CONV_NEG && cnt_end) begin
				cnt_q <= conv_len(radix_q);
			end else if (!cnt_end) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q          <= {2'b00, in_ch.value};
			carry_q        <= 1'b1;
			radix_q        <= in_ch.radix;
			dig_q          <= '0;
			ndig_q         <= NDIG_W'(NDIG);
			flags_q.digits <= '0;
			flags_q.ndig   <= '0;
			flags_q.neg    <= in_neg;
			flags_q.upper  <= in_ch.upper_hex;
			flags_q.hexp   <= in_ch.hex_prefix;
			flags_q.octp   <= in_ch.octal_prefix;
			flags_q.zpad   <= in_ch.zero_pad;
			flags_q.left   <= in_ch.left_justify;
			flags_q.width  <= in_ch.field_width;
		end else begin
			case (state_q)
				CONV_NEG: begin
					// rotate right one nibble, replacing it by its negated form
					mag_q[VAL_W-1:0] <= {nsum[DIG_W-1:0], mag_q[VAL_W-1:DIG_W]};
					carry_q          <= nsum[DIG_W];
				end
				CONV_SHIFT: begin
					case (radix_q)
						RADIX_OCT: begin
							dig_q <= {dig_q[DBUF_W-DIG_W-1:0], 1'b0, mag_q[MAG_W-1 -: 3]};
							mag_q <= {mag_q[MAG_W-4:0], 3'b000};
						end
						RADIX_DEC: begin
							dig_q <= {dabble[DBUF_W-2:0], mag_q[VAL_W-1]};
							mag_q <= {mag_q[MAG_W-2:0], 1'b0};
						end
						default: begin
							dig_q <= {dig_q[DBUF_W-DIG_W-1:0], mag_q[VAL_W-1 -: DIG_W]};
							mag_q <= {mag_q[MAG_W-DIG_W-1:0], {DIG_W{1'b0}}};
						end
					endcase
				end
				CONV_ALIGN: begin
					if (!align_end) begin
						dig_q  <= {dig_q[DBUF_W-DIG_W-1:0], {DIG_W{1'b0}}};
						ndig_q <= ndig_q - NDIG_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/itf_emit.sv]
// ----------------------------------------------------------------------------
// itf_emit
// character sequencer: lays out padding, sign, prefixes and digits and, while
// not stalled, sends one character per cycle through an output register
// ----------------------------------------------------------------------------
module itf_emit import itf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	output logic       res_ready,
	input  conv_res_t  res,
	itf_out_if.source  out_ch
);

	emit_state_t       state_q, state_nx;
	logic [FW_W-1:0]   idx_q;
	logic [FW_W-1:0]   lp_end_q, sgn_end_q, hx_end_q, zp_end_q, dg_end_q, last_q;
	logic [DBUF_W-1:0] dig_q;
	logic              upper_q;
	logic              ovalid_q;
	logic [7:0]        char_q;
	logic              lastc_q;

	logic              load;
	logic              step;
	logic              at_last;
	logic              in_dig;
	logic [7:0]        ch;
	logic [FW_W-1:0]   len, pad, lp, zp, sgn_end, hx_end, oc_end, zp_end, dg_end;

	// region boundaries of the text, from the converted value
	always_comb begin
		len = FW_W'(res.ndig) + FW_W'(res.neg) + FW_W'(res.octp) + FW_W'({res.hexp, 1'b0});
		pad = (res.width > len) ? res.width - len : '0;
		lp  = (!res.zpad && !res.left) ? pad : '0;
		zp  = res.zpad ? pad : '0;
		sgn_end = lp + FW_W'(res.neg);
		hx_end  = sgn_end + FW_W'({res.hexp, 1'b0});
		oc_end  = hx_end + FW_W'(res.octp);
		zp_end  = oc_end + zp;
		dg_end  = zp_end + FW_W'(res.ndig);
	end

	// character at the current position
	always_comb begin
		in_dig = 1'b0;
		if (idx_q < lp_end_q) begin
			ch = CH_SPACE;
		end else if (idx_q < sgn_end_q) begin
			ch = CH_MINUS;
		end else if (idx_q < hx_end_q) begin
			ch = (idx_q == sgn_end_q) ? CH_ZERO : CH_X;
		end else if (idx_q < zp_end_q) begin
			ch = CH_ZERO;
		end else if (idx_q < dg_end_q) begin
			ch     = digit_char(dig_q[DBUF_W-1 -: DIG_W], upper_q);
			in_dig = 1'b1;
		end else begin
			ch = CH_SPACE;
		end
	end

	assign at_last = (idx_q == last_q);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			EMIT_IDLE: if (res_valid) state_nx = EMIT_RUN;
			EMIT_RUN:  if (step && at_last) state_nx = EMIT_IDLE;
			default:   state_nx = EMIT_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		res_ready        = (state_q == EMIT_IDLE);
		load             = res_valid && res_ready;
		step             = (state_q == EMIT_RUN) && (!ovalid_q || out_ch.ready);
		out_ch.valid     = ovalid_q;
		out_ch.character = char_q;
		out_ch.last_char = lastc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= EMIT_IDLE;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (step) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			if (load) begin
				idx_q <= '0;
			end else if (step) begin
				idx_q <= idx_q + FW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lp_end_q  <= lp;
			sgn_end_q <= sgn_end;
			hx_end_q  <= hx_end;
			zp_end_q  <= zp_end;
			dg_end_q  <= dg_end;
			last_q    <= ((res.width > len) ? res.width : len) - FW_W'(1);
			dig_q     <= res.digits;
			upper_q   <= res.upper;
		end else if (step) begin
			char_q  <= ch;
			lastc_q <= at_last;
			if (in_dig) begin
				dig_q <= {dig_q[DBUF_W-DIG_W-1:0], {DIG_W{1'b0}}};
			end
		end
	end

endmodule

[rtl/integer_text_formatter.sv]
// ----------------------------------------------------------------------------
// integer_text_formatter
// formats a 64-bit integer as printf-style ascii text, one character per
// output transaction, with the final character of each value marked
// ----------------------------------------------------------------------------
// path: from input to first character valid, a negative signed value is
//   first negated, then digits are extracted for octal, decimal or hex,
//   leading zero digits are stripped, and the value is handed to the
//   emitter and passes its output register
// throughput: one character per cycle within a value while the output is
//   not stalled; a new value is taken once the converter has handed its
//   digits to the emitter, so conversion overlaps the output of the previous
//   value
// reset: arst_n clears both state machines and the output valid at once
// ----------------------------------------------------------------------------
module integer_text_formatter import itf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	itf_in_if.sink    in_ch,
	itf_out_if.source out_ch
);

	// converter to emitter handoff
	logic      res_valid;
	logic      res_ready;
	conv_res_t res;

	// digit-serial conversion: magnitude, then digits one per cycle (one bit
	// per cycle through the bcd register for decimal)
	itf_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// character sequencer with its output register, shifting digits out
	// of the top of the digit register
	itf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_ch    (out_ch)
	);

endmodule

[rtl/itf_checker.sv]
// ----------------------------------------------------------------------------
// itf_checker
// port-level checks of the integer text formatter
// ----------------------------------------------------------------------------
module itf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_character,
	input logic       out_last
);

	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// values taken but not yet closed by a last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b00, in_acc} - {2'b00, out_acc && out_last};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
		else $error("stalled output transaction changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input taken again before conversion");

	a_no_spurious_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 3'd0)
		else $error("character without a pending value");

	// output register, emitter and converter hold one value each at most
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("more than three values in flight");

endmodule

bind integer_text_formatter itf_checker u_itf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_character (out_ch.character),
	.out_last      (out_ch.last_char)
);
